### rtl/steq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer event queue package
// Field widths, operation and status codes, the stored entry type and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package steq_pkg;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned ZONE_W    = 8;
  localparam int unsigned ACT_W     = 3;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned OCC_W     = 9;
  localparam int unsigned DEPTH_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_FIND   = 3'd1,
    OP_DELETE = 3'd2,
    OP_READ   = 3'd3,
    OP_DUE    = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_INS_RD,
    S_INS_MV,
    S_DEL_RD,
    S_DEL_MV,
    S_POINT_RD,
    S_POINT_CHK,
    S_FINISH
  } state_e;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX_M1,
    RD_POINT
  } mem_rd_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_UP,
    WR_DOWN,
    WR_NEW
  } mem_wr_e;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_CLEAR,
    IDX_INC,
    IDX_DEC
  } idx_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_e;

  typedef struct packed {
    logic [TIME_W-1:0] ev_time;
    logic [ZONE_W-1:0] zone;
    logic [ACT_W-1:0]  action;
  } entry_t;

  typedef struct packed {
    logic    accept;
    logic    mem_rd;
    mem_rd_e rd_sel;
    mem_wr_e wr_sel;
    idx_e    idx_op;
    cnt_e    cnt_op;
    logic    scan_chk;
    logic    res_load;
    status_e res_code;
    logic    res_data;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            idx_end;
    logic            idx_at;
    logic            full;
    logic            dup;
    logic            zone_hit;
    logic            point_ok;
    logic            due_ok;
    logic            out_free;
  } dp_stat_t;

endpackage

### rtl/steq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer event queue channels
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface steq_req_if import steq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [TIME_W-1:0] event_time;
  logic [ZONE_W-1:0] zone_id;
  logic [ACT_W-1:0]  action_code;
  logic [POS_W-1:0]  position;
  logic [TIME_W-1:0] now_time;

  modport source (
    output valid, op, event_time, zone_id, action_code, position, now_time,
    input  ready
  );
  modport sink (
    input  valid, op, event_time, zone_id, action_code, position, now_time,
    output ready
  );
endinterface

interface steq_rsp_if import steq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ZONE_W-1:0] out_zone;
  logic [TIME_W-1:0] out_time;
  logic [ACT_W-1:0]  out_action;
  logic [OCC_W-1:0]  occupancy;

  modport source (
    output valid, status, out_zone, out_time, out_action, occupancy,
    input  ready
  );
  modport sink (
    input  valid, status, out_zone, out_time, out_action, occupancy,
    output ready
  );
endinterface

### rtl/steq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer event queue controller
// Sequences scans, shifts and single reads of the entry memory for each
// operation and hands the result to the output register.
// ----------------------------------------------------------------------------
module steq_ctrl import steq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output cmd_t     cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (stat_i.op) inside
          OP_INSERT, OP_FIND, OP_DELETE: state_d = S_SCAN_RD;
          OP_READ, OP_DUE:               state_d = S_POINT_RD;
          default:                       state_d = S_FINISH;
        endcase
      end
      S_SCAN_RD: begin
        if (!stat_i.idx_end) begin
          state_d = S_SCAN_CHK;
        end else if (stat_i.op == OP_INSERT && !stat_i.dup && !stat_i.full) begin
          state_d = S_INS_RD;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SCAN_CHK: begin
        if (stat_i.op == OP_FIND && stat_i.zone_hit) begin
          state_d = S_FINISH;
        end else if (stat_i.op == OP_DELETE && stat_i.zone_hit) begin
          state_d = S_DEL_RD;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_INS_RD:    state_d = stat_i.idx_at ? S_FINISH : S_INS_MV;
      S_INS_MV:    state_d = S_INS_RD;
      S_DEL_RD:    state_d = stat_i.idx_end ? S_FINISH : S_DEL_MV;
      S_DEL_MV:    state_d = S_DEL_RD;
      S_POINT_RD:  state_d = stat_i.point_ok ? S_POINT_CHK : S_FINISH;
      S_POINT_CHK: state_d = S_FINISH;
      S_FINISH: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.rd_sel   = RD_IDX;
    cmd_o.wr_sel   = WR_NONE;
    cmd_o.idx_op   = IDX_HOLD;
    cmd_o.cnt_op   = CNT_HOLD;
    cmd_o.res_code = ST_MISS;
    in_ready_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          cmd_o.idx_op = IDX_CLEAR;
        end
      end
      S_DISPATCH: begin
        case (stat_i.op) inside
          OP_INSERT, OP_FIND, OP_DELETE, OP_READ, OP_DUE: ;
          default: cmd_o.res_load = 1'b1;
        endcase
      end
      S_SCAN_RD: begin
        if (!stat_i.idx_end) begin
          cmd_o.mem_rd = 1'b1;
          cmd_o.rd_sel = RD_IDX;
        end else if (stat_i.op == OP_INSERT) begin
          if (stat_i.dup) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_code = ST_DUP;
          end else if (stat_i.full) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_code = ST_FULL;
          end
        end else begin
          cmd_o.res_load = 1'b1;
        end
      end
      S_SCAN_CHK: begin
        if (stat_i.op == OP_FIND && stat_i.zone_hit) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = ST_OK;
          cmd_o.res_data = 1'b1;
        end else if (stat_i.op == OP_DELETE && stat_i.zone_hit) begin
          cmd_o.idx_op = IDX_INC;
        end else begin
          cmd_o.scan_chk = (stat_i.op == OP_INSERT);
          cmd_o.idx_op   = IDX_INC;
        end
      end
      S_INS_RD: begin
        if (stat_i.idx_at) begin
          cmd_o.wr_sel   = WR_NEW;
          cmd_o.cnt_op   = CNT_INC;
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = ST_OK;
        end else begin
          cmd_o.mem_rd = 1'b1;
          cmd_o.rd_sel = RD_IDX_M1;
        end
      end
      S_INS_MV: begin
        cmd_o.wr_sel = WR_UP;
        cmd_o.idx_op = IDX_DEC;
      end
      S_DEL_RD: begin
        if (stat_i.idx_end) begin
          cmd_o.cnt_op   = CNT_DEC;
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = ST_OK;
        end else begin
          cmd_o.mem_rd = 1'b1;
          cmd_o.rd_sel = RD_IDX;
        end
      end
      S_DEL_MV: begin
        cmd_o.wr_sel = WR_DOWN;
        cmd_o.idx_op = IDX_INC;
      end
      S_POINT_RD: begin
        if (stat_i.point_ok) begin
          cmd_o.mem_rd = 1'b1;
          cmd_o.rd_sel = RD_POINT;
        end else begin
          cmd_o.res_load = 1'b1;
        end
      end
      S_POINT_CHK: begin
        cmd_o.res_load = 1'b1;
        if (stat_i.op == OP_READ || stat_i.due_ok) begin
          cmd_o.res_code = ST_OK;
          cmd_o.res_data = 1'b1;
        end
      end
      S_FINISH: begin
        cmd_o.out_load = stat_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

### rtl/steq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer event queue datapath
// Entry memory, scan index, insertion point, entry count, the staged result
// and the output register.
// ----------------------------------------------------------------------------
module steq_dp import steq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  steq_req_if.sink           req_i,
  steq_rsp_if.source         rsp_o,
  input  cmd_t               cmd_i,
  output dp_stat_t           stat_o
);

  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_q;
  entry_t item_q;

  logic [OP_W-1:0]   op_q;
  logic [POS_W-1:0]  pos_q;
  logic [TIME_W-1:0] now_q;

  logic [CW-1:0] idx_q, at_q, count_q, idx_m1;
  logic          dup_q, hit_q;

  status_e           res_status_q;
  logic [ZONE_W-1:0] res_zone_q;
  logic [TIME_W-1:0] res_time_q;
  logic [ACT_W-1:0]  res_act_q;

  logic              out_valid_q;
  logic [STAT_W-1:0] out_status_q;
  logic [ZONE_W-1:0] out_zone_q;
  logic [TIME_W-1:0] out_time_q;
  logic [ACT_W-1:0]  out_act_q;
  logic [OCC_W-1:0]  out_occ_q;

  logic [IW-1:0] raddr, waddr;
  entry_t        wdata;
  logic          use_zone, use_time, use_act;

  assign idx_m1 = idx_q - CW'(1);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_IDX:    raddr = idx_q[IW-1:0];
      RD_IDX_M1: raddr = idx_m1[IW-1:0];
      RD_POINT:  raddr = (op_q == OP_READ) ? pos_q[IW-1:0] : '0;
      default:   raddr = idx_q[IW-1:0];
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      WR_UP: begin
        waddr = idx_q[IW-1:0];
        wdata = rd_q;
      end
      WR_DOWN: begin
        waddr = idx_m1[IW-1:0];
        wdata = rd_q;
      end
      WR_NEW: begin
        waddr = at_q[IW-1:0];
        wdata = item_q;
      end
      default: begin
        waddr = idx_q[IW-1:0];
        wdata = rd_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_sel != WR_NONE) mem[waddr] <= wdata;
    if (cmd_i.mem_rd) rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q           <= req_i.op;
      item_q.ev_time <= req_i.event_time;
      item_q.zone    <= req_i.zone_id;
      item_q.action  <= req_i.action_code;
      pos_q          <= req_i.position;
      now_q          <= req_i.now_time;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      at_q    <= '0;
      count_q <= '0;
      dup_q   <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      case (cmd_i.idx_op)
        IDX_CLEAR: idx_q <= '0;
        IDX_INC:   idx_q <= idx_q + CW'(1);
        IDX_DEC:   idx_q <= idx_m1;
        default:   ;
      endcase
      case (cmd_i.cnt_op)
        CNT_INC: count_q <= count_q + CW'(1);
        CNT_DEC: count_q <= count_q - CW'(1);
        default: ;
      endcase
      if (cmd_i.accept) begin
        at_q  <= count_q;
        dup_q <= 1'b0;
        hit_q <= 1'b0;
      end else if (cmd_i.scan_chk) begin
        if (rd_q == item_q) dup_q <= 1'b1;
        if (!hit_q && rd_q.ev_time > item_q.ev_time) begin
          at_q  <= idx_q;
          hit_q <= 1'b1;
        end
      end
    end
  end

  assign use_zone = cmd_i.res_data &&
                    (op_q == OP_FIND || op_q == OP_READ || op_q == OP_DUE);
  assign use_time = cmd_i.res_data && (op_q == OP_FIND || op_q == OP_READ);
  assign use_act  = cmd_i.res_data && (op_q == OP_READ || op_q == OP_DUE);

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_code;
      res_zone_q   <= use_zone ? rd_q.zone : '0;
      res_time_q   <= use_time ? rd_q.ev_time : '0;
      res_act_q    <= use_act ? rd_q.action : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_zone_q   <= res_zone_q;
      out_time_q   <= res_time_q;
      out_act_q    <= res_act_q;
      out_occ_q    <= OCC_W'(count_q);
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.out_zone   = out_zone_q;
  assign rsp_o.out_time   = out_time_q;
  assign rsp_o.out_action = out_act_q;
  assign rsp_o.occupancy  = out_occ_q;

  assign stat_o.op       = op_q;
  assign stat_o.idx_end  = (idx_q == count_q);
  assign stat_o.idx_at   = (idx_q == at_q);
  assign stat_o.full     = (count_q == CW'(QUEUE_DEPTH));
  assign stat_o.dup      = dup_q;
  assign stat_o.zone_hit = (rd_q.zone == item_q.zone);
  assign stat_o.point_ok = (op_q == OP_READ) ?
                           ({1'b0, pos_q} < OCC_W'(count_q)) : (count_q != '0);
  assign stat_o.due_ok   = (rd_q.ev_time <= now_q);
  assign stat_o.out_free = !out_valid_q || rsp_o.ready;

endmodule

### rtl/sorted_timer_event_queue_unit.sv
`timescale 1ns / 1ps
// Read and due check make one read of the entry memory, none for a read past the end or an
// empty queue; find scans from index 0 to its first zone hit; delete scans to its hit and
// shifts the later entries down; insert scans all entries, then shifts those from its
// position up, or is rejected as a duplicate or full. One request is in flight at a time;
// the next is accepted the cycle after its result enters the output register, later while
// it stalls. Reset empties the queue at once; entry storage is not cleared.
// ----------------------------------------------------------------------------
// Sorted timer event queue
// Queue of timer events kept in ascending start-time order with insert, find,
// delete, indexed read and due check operations.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue_unit import steq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  steq_req_if.sink   in_i,
  steq_rsp_if.source out_o
);

  cmd_t     cmd;
  dp_stat_t stat;

  steq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  steq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_i),
    .rsp_o  (out_o),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer event queue testbench
// Drives insert, find, delete, read and due check requests through bursts
// and gaps, stalls the response channel on a changing pattern, and checks
// every response against a model of the sorted queue kept in the bench.
// ----------------------------------------------------------------------------
module tb_top import steq_pkg::*; ();

  localparam int unsigned QUEUE_DEPTH  = DEPTH_DEF;
  localparam int          RANDOM_ITEMS = 1275;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          DRAIN_CYCLES = 100;
  localparam int          HOLD_AT      = 400;
  localparam int          HOLD_CYCLES  = 600;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_ALTERNATE,
    RDY_MOSTLY,
    RDY_RARELY
  } ready_mode_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] event_time;
    logic [ZONE_W-1:0] zone_id;
    logic [ACT_W-1:0]  action_code;
    logic [POS_W-1:0]  position;
    logic [TIME_W-1:0] now_time;
  } timer_req_t;

  typedef struct packed {
    status_e           status;
    logic [ZONE_W-1:0] out_zone;
    logic [TIME_W-1:0] out_time;
    logic [ACT_W-1:0]  out_action;
    logic [OCC_W-1:0]  occupancy;
  } timer_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  steq_req_if req_if ();
  steq_rsp_if rsp_if ();

  sorted_timer_event_queue_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  always #6 clk_i = ~clk_i;

  timer_req_t  pending_req_q[$];
  timer_rsp_t  expected_rsp_q[$];
  entry_t      timer_store[$];
  entry_t      plan_store[$];
  int          errors = 0;
  int          rsp_count = 0;
  int          cycle_count = 0;

  // Driver state.
  int          burst_left = 0;
  int          gap_left = 0;
  timer_req_t  accepted_req;
  timer_req_t  next_req;

  // Receiver state.
  ready_mode_e ready_mode = RDY_ALWAYS;
  int          mode_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  bit          alt_ready = 1'b0;
  logic        ready_next;
  timer_rsp_t  exp_rsp;

  function automatic timer_rsp_t apply_timer_op(ref entry_t store[$], input timer_req_t req);
    timer_rsp_t rsp;
    entry_t     ent;
    int         hit;
    int         at;
    bit         dup;
    rsp        = '0;
    rsp.status = ST_MISS;
    hit        = -1;
    dup        = 1'b0;
    ent.ev_time = req.event_time;
    ent.zone    = req.zone_id;
    ent.action  = req.action_code;
    if (req.op == OP_FIND || req.op == OP_DELETE) begin
      for (int i = 0; i < store.size(); i++) begin
        if (hit < 0 && store[i].zone == req.zone_id) hit = i;
      end
    end
    case (req.op)
      OP_INSERT: begin
        foreach (store[i]) begin
          if (store[i] == ent) dup = 1'b1;
        end
        if (dup) begin
          rsp.status = ST_DUP;
        end else if (store.size() >= QUEUE_DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          at = 0;
          while (at < store.size() && store[at].ev_time <= req.event_time) at++;
          store.insert(at, ent);
          rsp.status = ST_OK;
        end
      end
      OP_FIND: begin
        if (hit >= 0) begin
          rsp.status   = ST_OK;
          rsp.out_zone = store[hit].zone;
          rsp.out_time = store[hit].ev_time;
        end
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          store.delete(hit);
          rsp.status = ST_OK;
        end
      end
      OP_READ: begin
        if (int'(req.position) < store.size()) begin
          rsp.status     = ST_OK;
          rsp.out_zone   = store[req.position].zone;
          rsp.out_time   = store[req.position].ev_time;
          rsp.out_action = store[req.position].action;
        end
      end
      OP_DUE: begin
        if (store.size() > 0 && store[0].ev_time <= req.now_time) begin
          rsp.status     = ST_OK;
          rsp.out_zone   = store[0].zone;
          rsp.out_action = store[0].action;
        end
      end
      default: begin
      end
    endcase
    rsp.occupancy = OCC_W'(store.size());
    return rsp;
  endfunction

  function automatic timer_req_t random_req();
    timer_req_t r;
    r.op          = OP_W'($urandom_range(0, 7));
    r.event_time  = $urandom();
    r.zone_id     = ZONE_W'($urandom());
    r.action_code = ACT_W'($urandom());
    r.position    = POS_W'($urandom());
    r.now_time    = $urandom();
    return r;
  endfunction

  function automatic timer_req_t mk_req(op_e op, logic [TIME_W-1:0] t, logic [ZONE_W-1:0] z,
                                        logic [ACT_W-1:0] a, logic [POS_W-1:0] p,
                                        logic [TIME_W-1:0] n);
    timer_req_t r;
    r.op          = op;
    r.event_time  = t;
    r.zone_id     = z;
    r.action_code = a;
    r.position    = p;
    r.now_time    = n;
    return r;
  endfunction

  function automatic void plan_req(timer_req_t r);
    void'(apply_timer_op(plan_store, r));
    pending_req_q.push_back(r);
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
    end
  endtask

  // Request driver: bursts of transactions separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid       <= 1'b0;
      req_if.op          <= '0;
      req_if.event_time  <= '0;
      req_if.zone_id     <= '0;
      req_if.action_code <= '0;
      req_if.position    <= '0;
      req_if.now_time    <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        accepted_req.op          = req_if.op;
        accepted_req.event_time  = req_if.event_time;
        accepted_req.zone_id     = req_if.zone_id;
        accepted_req.action_code = req_if.action_code;
        accepted_req.position    = req_if.position;
        accepted_req.now_time    = req_if.now_time;
        expected_rsp_q.push_back(apply_timer_op(timer_store, accepted_req));
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (pending_req_q.size() > 0) begin
          next_req = pending_req_q.pop_front();
          req_if.valid       <= 1'b1;
          req_if.op          <= next_req.op;
          req_if.event_time  <= next_req.event_time;
          req_if.zone_id     <= next_req.zone_id;
          req_if.action_code <= next_req.action_code;
          req_if.position    <= next_req.position;
          req_if.now_time    <= next_req.now_time;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor with its own stall pattern and one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_count++;
        if (expected_rsp_q.size() == 0) begin
          errors++;
          $display("%0t: response transaction with nothing expected, status %0d", $time,
                   rsp_if.status);
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          check_field("status", 32'(exp_rsp.status), 32'(rsp_if.status));
          check_field("out_zone", 32'(exp_rsp.out_zone), 32'(rsp_if.out_zone));
          check_field("out_time", exp_rsp.out_time, rsp_if.out_time);
          check_field("out_action", 32'(exp_rsp.out_action), 32'(rsp_if.out_action));
          check_field("occupancy", 32'(exp_rsp.occupancy), 32'(rsp_if.occupancy));
        end
      end
      if (!hold_done && rsp_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = ready_mode_e'($urandom_range(0, 3));
          mode_left  = $urandom_range(20, 300);
        end else begin
          mode_left--;
        end
        alt_ready = ~alt_ready;
        case (ready_mode)
          RDY_ALWAYS:    ready_next = 1'b1;
          RDY_ALTERNATE: ready_next = alt_ready;
          RDY_MOSTLY:    ready_next = ($urandom_range(0, 3) != 0);
          default:       ready_next = ($urandom_range(0, 3) == 0);
        endcase
      end
      rsp_if.ready <= ready_next;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    timer_req_t r;
    bit         filling;
    int         roll;
    int         pick;
    int         ins_th;
    int         del_th;
    rst_ni  = 1'b0;
    filling = 1'b1;

    // Directed part: empty queue, extremes, equal times, duplicates, misses.
    plan_req(mk_req(OP_DUE, 32'h0, 8'h0, 3'd0, 8'h0, 32'hFFFF_FFFF));
    plan_req(mk_req(OP_READ, 32'h0, 8'h0, 3'd0, 8'h0, 32'h0));
    plan_req(mk_req(OP_FIND, 32'h0, 8'h0, 3'd0, 8'h0, 32'h0));
    plan_req(mk_req(OP_DELETE, 32'h0, 8'hFF, 3'd0, 8'h0, 32'h0));
    plan_req(mk_req(OP_INSERT, 32'd100, 8'd1, 3'd0, 8'h0, 32'h0));
    plan_req(mk_req(OP_INSERT, 32'd100, 8'd2, 3'd7, 8'hFF, 32'hFFFF_FFFF));
    plan_req(mk_req(OP_INSERT, 32'h0, 8'hFF, 3'd3, 8'h0, 32'h0));
    plan_req(mk_req(OP_INSERT, 32'hFFFF_FFFF, 8'h0, 3'd7, 8'h0, 32'h0));
    plan_req(mk_req(OP_INSERT, 32'd100, 8'd1, 3'd0, 8'h0, 32'h0));
    plan_req(mk_req(OP_INSERT, 32'd100, 8'd1, 3'd5, 8'h0, 32'h0));
    plan_req(mk_req(OP_FIND, 32'h0, 8'd1, 3'd0, 8'h0, 32'h0));
    plan_req(mk_req(OP_FIND, 32'hFFFF_FFFF, 8'd9, 3'd7, 8'hFF, 32'hFFFF_FFFF));
    for (int i = 0; i <= 5; i++) begin
      plan_req(mk_req(OP_READ, 32'h0, 8'h0, 3'd0, POS_W'(i), 32'h0));
    end
    plan_req(mk_req(OP_READ, 32'h0, 8'h0, 3'd0, 8'hFF, 32'h0));
    plan_req(mk_req(OP_DUE, 32'h0, 8'h0, 3'd0, 8'h0, 32'h0));
    plan_req(mk_req(OP_DELETE, 32'h0, 8'hFF, 3'd0, 8'h0, 32'h0));
    plan_req(mk_req(OP_DUE, 32'h0, 8'h0, 3'd0, 8'h0, 32'd99));
    plan_req(mk_req(OP_DUE, 32'h0, 8'h0, 3'd0, 8'h0, 32'hFFFF_FFFF));
    plan_req(mk_req(OP_DELETE, 32'h0, 8'd1, 3'd0, 8'h0, 32'h0));
    for (int i = 5; i <= 7; i++) begin
      r    = random_req();
      r.op = OP_W'(i);
      plan_req(r);
    end

    // Random part: alternating fill and drain phases over a small zone set.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = random_req();
      if (plan_store.size() >= QUEUE_DEPTH && $urandom_range(0, 5) == 0) filling = 1'b0;
      if (plan_store.size() == 0) filling = 1'b1;
      ins_th = filling ? 50 : 18;
      del_th = filling ? 62 : 58;
      roll   = $urandom_range(0, 99);
      if (roll < 3) begin
        r.op = OP_W'($urandom_range(5, 7));
      end else if (roll < ins_th) begin
        r.op = OP_INSERT;
        if (plan_store.size() > 0 && $urandom_range(0, 7) == 0) begin
          pick          = $urandom_range(0, plan_store.size() - 1);
          r.event_time  = plan_store[pick].ev_time;
          r.zone_id     = plan_store[pick].zone;
          r.action_code = plan_store[pick].action;
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
              if (plan_store.size() > 0) begin
                pick         = $urandom_range(0, plan_store.size() - 1);
                r.event_time = plan_store[pick].ev_time + $urandom_range(0, 2) - 1;
              end else begin
                r.event_time = $urandom_range(0, 63);
              end
            end
            4, 5, 6: r.event_time = $urandom_range(0, 63);
            7, 8:    r.event_time = $urandom();
            default: r.event_time = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
          endcase
          if ($urandom_range(0, 9) < 7) r.zone_id = ZONE_W'($urandom_range(0, 7));
        end
      end else if (roll < 74) begin
        r.op = (roll < del_th) ? OP_DELETE : OP_FIND;
        if (plan_store.size() > 0 && $urandom_range(0, 9) < 7) begin
          r.zone_id = plan_store[$urandom_range(0, plan_store.size() - 1)].zone;
        end else if ($urandom_range(0, 1) == 0) begin
          r.zone_id = ZONE_W'($urandom_range(0, 7));
        end
      end else if (roll < 87) begin
        r.op = OP_READ;
        if ($urandom_range(0, 9) < 8) r.position = POS_W'($urandom_range(0, plan_store.size() + 1));
      end else begin
        r.op = OP_DUE;
        if (plan_store.size() > 0) begin
          case ($urandom_range(0, 5))
            0: r.now_time = plan_store[0].ev_time;
            1: r.now_time = plan_store[0].ev_time - 1;
            2: r.now_time = plan_store[0].ev_time + 1;
            3: r.now_time = 32'h0;
            4: r.now_time = 32'hFFFF_FFFF;
            default: r.now_time = $urandom();
          endcase
        end
      end
      plan_req(r);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_req_q.size() != 0 || req_if.valid) @(posedge clk_i);
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && expected_rsp_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/steq_pkg.sv
rtl/steq_if.sv
rtl/steq_ctrl.sv
rtl/steq_dp.sv
rtl/sorted_timer_event_queue_unit.sv
tb/tb_top.sv
